// File: rtl/core/elev_pkg.sv
package elev_pkg;

  localparam int MAX_FLOORS        = 15;
  localparam int FLOOR_COUNT_DEF   = 6;
  localparam int FLOOR_W           = 4;
  localparam int TICK_W            = 8;
  localparam int STATE_W           = 3;
  localparam int APB_DATA_W        = 32;
  localparam int APB_ADDR_W        = 4;

  localparam logic [TICK_W-1:0] TRAVEL_RST  = TICK_W'(10);
  localparam logic [TICK_W-1:0] OPENING_RST = TICK_W'(5);
  localparam logic [TICK_W-1:0] OPEN_RST    = TICK_W'(20);
  localparam logic [TICK_W-1:0] CLOSING_RST = TICK_W'(5);

  localparam logic [1:0] REG_TRAVEL  = 2'd0;
  localparam logic [1:0] REG_OPENING = 2'd1;
  localparam logic [1:0] REG_OPEN    = 2'd2;
  localparam logic [1:0] REG_CLOSING = 2'd3;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_UP      = 3'd1,
    ST_DOWN    = 3'd2,
    ST_OPENING = 3'd3,
    ST_OPEN    = 3'd4,
    ST_CLOSING = 3'd5
  } car_state_e;

  typedef struct packed {
    logic [TICK_W-1:0] travel;
    logic [TICK_W-1:0] opening;
    logic [TICK_W-1:0] open_t;
    logic [TICK_W-1:0] closing;
  } timing_t;

  typedef struct packed {
    car_state_e              state;
    logic [FLOOR_W-1:0]      floor;
    logic [FLOOR_W-1:0]      target;
    logic                    tgt_valid;
    logic [MAX_FLOORS-1:0]   pending;
    logic [MAX_FLOORS-1:0]   lamp;
  } car_status_t;

endpackage

// File: rtl/core/elev_fsm.sv
module elev_fsm
  import elev_pkg::*;
#(
  parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_en_i,
  input  logic               command_i,
  input  logic [FLOOR_W-1:0] requested_floor_i,
  input  timing_t            timing_i,
  output car_status_t        status_o
);

  car_state_e              state_q, state_d;
  logic [FLOOR_W-1:0]      car_q, car_d;
  logic [FLOOR_W-1:0]      goal_q, goal_d;
  logic [FLOOR_COUNT-1:0]  pend_q, pend_d;
  logic [TICK_W-1:0]       phase_q, phase_d;

  logic                    is_tick;
  logic [FLOOR_COUNT-1:0]  req_bit;
  logic [FLOOR_COUNT-1:0]  pend_v;
  logic [TICK_W-1:0]       phase_v;

  // target selection: current floor, then nearest above, then nearest below
  logic [FLOOR_W-1:0]      above_fl, below_fl, tgt_fl;
  logic                    above_hit, below_hit, here_hit;
  logic [FLOOR_COUNT-1:0]  here_bit;

  // arrival at next floor while moving
  logic [FLOOR_W-1:0]      next_fl;
  logic [FLOOR_COUNT-1:0]  next_bit;
  logic                    reached;

  always_comb begin
    is_tick = (command_i == CMD_TICK);
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      req_bit[i]  = (requested_floor_i == FLOOR_W'(i + 1));
      here_bit[i] = (car_q == FLOOR_W'(i + 1));
    end
    pend_v  = is_tick ? pend_q : (pend_q | req_bit);
    phase_v = is_tick ? phase_q + TICK_W'(1) : phase_q;

    here_hit  = |(pend_v & here_bit);
    above_hit = 1'b0;
    above_fl  = car_q;
    for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
      if (pend_v[i] && FLOOR_W'(i + 1) > car_q) begin
        above_hit = 1'b1;
        above_fl  = FLOOR_W'(i + 1);
      end
    end
    below_hit = 1'b0;
    below_fl  = car_q;
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      if (pend_v[i] && FLOOR_W'(i + 1) < car_q) begin
        below_hit = 1'b1;
        below_fl  = FLOOR_W'(i + 1);
      end
    end
    if (here_hit) begin
      tgt_fl = car_q;
    end else if (above_hit) begin
      tgt_fl = above_fl;
    end else if (below_hit) begin
      tgt_fl = below_fl;
    end else begin
      tgt_fl = car_q;
    end

    next_fl = (state_q == ST_UP) ? car_q + FLOOR_W'(1) : car_q - FLOOR_W'(1);
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      next_bit[i] = (next_fl == FLOOR_W'(i + 1));
    end
    reached = (state_q == ST_UP) ? (next_fl >= goal_q) : (next_fl <= goal_q);
  end

  always_comb begin
    state_d = state_q;
    car_d   = car_q;
    goal_d  = goal_q;
    pend_d  = pend_v;
    phase_d = phase_v;

    unique case (state_q) inside
      ST_IDLE, ST_CLOSING: begin
        if ((state_q == ST_IDLE && !is_tick) ||
            (state_q == ST_CLOSING && is_tick && phase_v >= timing_i.closing)) begin
          phase_d = '0;
          if (pend_v == '0) begin
            state_d = ST_IDLE;
          end else begin
            goal_d = tgt_fl;
            if (tgt_fl > car_q) begin
              state_d = ST_UP;
            end else if (tgt_fl < car_q) begin
              state_d = ST_DOWN;
            end else begin
              pend_d  = pend_v & ~here_bit;
              state_d = ST_OPENING;
            end
          end
        end
      end
      ST_UP, ST_DOWN: begin
        if (is_tick && phase_v >= timing_i.travel) begin
          phase_d = '0;
          car_d   = next_fl;
          if (reached || |(pend_v & next_bit)) begin
            pend_d  = pend_v & ~next_bit;
            state_d = ST_OPENING;
          end
        end
      end
      ST_OPENING: begin
        if (is_tick && phase_v >= timing_i.opening) begin
          phase_d = '0;
          state_d = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (is_tick && phase_v >= timing_i.open_t) begin
          phase_d = '0;
          state_d = ST_CLOSING;
        end
      end
      default: begin
        phase_d = '0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      car_q   <= FLOOR_W'(1);
      goal_q  <= FLOOR_W'(1);
      pend_q  <= '0;
      phase_q <= '0;
    end else if (item_en_i) begin
      state_q <= state_d;
      car_q   <= car_d;
      goal_q  <= goal_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
    end
  end

  // result of this item, taken from the post-update state
  always_comb begin
    status_o           = '0;
    status_o.state     = state_d;
    status_o.floor     = car_d;
    status_o.tgt_valid = !(state_d == ST_IDLE && pend_d == '0);
    status_o.target    = status_o.tgt_valid ? goal_d : '0;
    status_o.pending   = MAX_FLOORS'(pend_d);
    for (int i = 0; i < MAX_FLOORS; i++) begin
      status_o.lamp[i] = (car_d == FLOOR_W'(i + 1));
    end
  end

endmodule

// File: rtl/core/elevator_controller_top.sv
// An accepted request's result is written into the output register and shown in the next cycle.
// Throughput: one request per cycle; a new request is taken whenever the output
// register is empty or being emptied in the same cycle.
// Reset (rst_ni low, asynchronous): car idle at floor 1, no pending floors,
// output empty, timing registers back to 10/5/20/5 ticks.
module elevator_controller_top
  import elev_pkg::*;
#(
  parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [FLOOR_W-1:0]    requested_floor_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATE_W-1:0]    car_state_o,
  output logic [FLOOR_W-1:0]    current_floor_o,
  output logic [FLOOR_W-1:0]    target_floor_o,
  output logic                  target_valid_o,
  output logic [MAX_FLOORS-1:0] pending_mask_o,
  output logic [MAX_FLOORS-1:0] floor_indicator_o
);

  timing_t     timing_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;
  logic        accept;
  logic        out_valid_q;
  car_status_t status_d, status_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.travel  <= TRAVEL_RST;
      timing_q.opening <= OPENING_RST;
      timing_q.open_t  <= OPEN_RST;
      timing_q.closing <= CLOSING_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRAVEL:  timing_q.travel  <= pwdata[TICK_W-1:0];
        REG_OPENING: timing_q.opening <= pwdata[TICK_W-1:0];
        REG_OPEN:    timing_q.open_t  <= pwdata[TICK_W-1:0];
        REG_CLOSING: timing_q.closing <= pwdata[TICK_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRAVEL:  prdata = APB_DATA_W'(timing_q.travel);
      REG_OPENING: prdata = APB_DATA_W'(timing_q.opening);
      REG_OPEN:    prdata = APB_DATA_W'(timing_q.open_t);
      REG_CLOSING: prdata = APB_DATA_W'(timing_q.closing);
      default:     prdata = '0;
    endcase
  end

  // output register drains in the same cycle it refills
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  elev_fsm #(
    .FLOOR_COUNT(FLOOR_COUNT)
  ) u_fsm (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_en_i         (accept),
    .command_i         (command_i),
    .requested_floor_i (requested_floor_i),
    .timing_i          (timing_q),
    .status_o          (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign car_state_o       = status_q.state;
  assign current_floor_o   = status_q.floor;
  assign target_floor_o    = status_q.target;
  assign target_valid_o    = status_q.tgt_valid;
  assign pending_mask_o    = status_q.pending;
  assign floor_indicator_o = status_q.lamp;

endmodule

// File: rtl/core/elev_chk.sv
module elev_chk
  import elev_pkg::*;
#(
  parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [STATE_W-1:0]    car_state_o,
  input logic [FLOOR_W-1:0]    target_floor_o,
  input logic                  target_valid_o,
  input logic [MAX_FLOORS-1:0] floor_indicator_o
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  a_lamp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(floor_indicator_o))
    else $error("floor lamp not one-hot");

  a_tgt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !target_valid_o |-> target_floor_o == '0 &&
      car_state_o == STATE_W'(ST_IDLE))
    else $error("target shown without a target");

  a_busy_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && car_state_o != STATE_W'(ST_IDLE) |->
      target_valid_o && target_floor_o != '0 &&
      target_floor_o <= FLOOR_W'(FLOOR_COUNT))
    else $error("busy car has no sane target");

endmodule

bind elevator_controller_top elev_chk #(
  .FLOOR_COUNT(FLOOR_COUNT)
) u_elev_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .car_state_o       (car_state_o),
  .target_floor_o    (target_floor_o),
  .target_valid_o    (target_valid_o),
  .floor_indicator_o (floor_indicator_o)
);
